@@ sv/bpsr_pkg.sv @@
package bpsr_pkg;

  localparam int FRAC_BITS = 24;
  localparam int LOG_FRAC  = 30;
  localparam logic [47:0] BRIGHT_TOP = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_ZERO_RAD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQX,
    ST_SQY,
    ST_RSQ,
    ST_NORM,
    ST_LOG,
    ST_MULE,
    ST_EXP,
    ST_PEAK
  } state_t;

  typedef struct packed {
    logic [13:0] cx;
    logic [13:0] cy;
    logic [31:0] peak;
    logic [15:0] rad;
  } src_t;

  typedef logic [31:0] root_tab_t [0:FRAC_BITS];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    int i;
    res = '0;
    bt  = 64'h1 << 62;
    rem = v;
    for (i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Q.31 factors 2^(-2^-k); entry zero is never used.
  function automatic root_tab_t build_roots();
    root_tab_t t;
    logic [63:0] prev;
    int k;
    t[0] = 32'h4000_0000;
    prev = isqrt64(64'h1 << 61);
    t[1] = prev[31:0];
    for (k = 2; k <= FRAC_BITS; k++) begin
      prev = isqrt64(prev << 31);
      t[k] = prev[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

@@ sv/beta_profile_sum_renderer.sv @@
// Channel     | Handshake          | Payload
// ------------+--------------------+-------------------------------------------------
// input       | start, busy        | in_op, in_pos_x, in_pos_y, in_peak, in_core_radius
// result      | out_valid (strobe) | out_brightness, out_status, out_source_count
// config      | cfg_we             | cfg_wdata (falloff exponent)
//
// Clear and add items give their result in the cycle after acceptance.
// A pixel item runs one shared multiplier over every stored source, one source
// at a time: two 30-step log squarings, the normalizing shifts and the 24-step
// exponent product chain per source.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// The receiver cannot stall; each result is shown for one cycle only.
module beta_profile_sum_renderer
  import bpsr_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  localparam int CNT_W = $clog2(MAX_SOURCES + 1),
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic signed [13:0] in_pos_x,
  input  logic signed [13:0] in_pos_y,
  input  logic [31:0]       in_peak,
  input  logic [15:0]       in_core_radius,
  output logic              out_valid,
  output logic [47:0]       out_brightness,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_source_count,
  input  logic              cfg_we,
  input  logic [13:0]       cfg_wdata
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [13:0] exp_r;
  logic out_valid_r, out_valid_nxt;
  logic [47:0] out_bright_r;
  logic [1:0]  out_status_r;
  logic [CNT_W-1:0] out_count_r;

  src_t mem [0:MAX_SOURCES-1];
  src_t rd_r;
  logic [CNT_W-1:0] idx_r;

  logic signed [13:0] qx_r, qy_r;
  logic [29:0] d2_r;
  logic [31:0] r2_r;
  logic [39:0] nz_r;
  logic [5:0]  p_r;
  logic [31:0] z_r;
  logic [4:0]  lbit_r;
  logic [29:0] lfrac_r;
  logic        log_sel_r;
  logic [35:0] la_r, l_r;
  logic [7:0]  n_r;
  logic [23:0] f_r;
  logic [4:0]  k_r;
  logic [31:0] acc_r;
  logic [47:0] bright_r;

  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [67:0] mul_p;

  logic accept, add_ok, more_src;
  logic signed [14:0] dx, dy;
  logic [14:0] ax, ay;
  logic [32:0] sq_t;
  logic [29:0] frac_upd;
  logic [35:0] lb;
  logic [5:0]  sh;
  logic [63:0] term;
  logic [64:0] sum;
  logic [1:0]  acc_status;

  assign accept   = start && (state_r == ST_IDLE);
  assign add_ok   = (in_core_radius != 16'd0) && (count_r < CNT_W'(MAX_SOURCES));
  assign more_src = (idx_r + 1'b1) < count_r;

  assign dx = {qx_r[13], qx_r} - {rd_r.cx[13], rd_r.cx};
  assign dy = {qy_r[13], qy_r} - {rd_r.cy[13], rd_r.cy};
  assign ax = dx[14] ? 15'(-dx) : 15'(dx);
  assign ay = dy[14] ? 15'(-dy) : 15'(dy);

  assign mul_p    = {32'd0, mul_a} * {36'd0, mul_b};
  assign sq_t     = mul_p[63:31];
  assign frac_upd = lfrac_r | (sq_t[32] ? (30'd1 << lbit_r) : 30'd0);
  assign lb       = {p_r, frac_upd};
  assign sh       = 6'(n_r) + 6'd31;
  assign term     = (n_r > 8'd32) ? 64'd0 : (mul_p[63:0] >> sh);
  assign sum      = {17'd0, bright_r} + {1'b0, term};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_PIXEL && count_r != '0) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_RSQ;
      ST_RSQ:  state_nxt = ST_NORM;
      ST_NORM: begin
        if (nz_r[39] || nz_r == '0) state_nxt = ST_LOG;
      end
      ST_LOG: begin
        if (lbit_r == 5'd0) state_nxt = log_sel_r ? ST_MULE : ST_NORM;
      end
      ST_MULE: state_nxt = ST_EXP;
      ST_EXP: begin
        if (k_r == 5'(FRAC_BITS)) state_nxt = ST_PEAK;
      end
      ST_PEAK: state_nxt = more_src ? ST_READ : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Shared multiplier operands and handshake outputs.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX:  begin mul_a = 36'(ax); mul_b = 32'(ax); end
      ST_SQY:  begin mul_a = 36'(ay); mul_b = 32'(ay); end
      ST_RSQ:  begin mul_a = 36'(rd_r.rad); mul_b = 32'(rd_r.rad); end
      ST_LOG:  begin mul_a = 36'(z_r); mul_b = z_r; end
      ST_MULE: begin mul_a = l_r; mul_b = 32'(exp_r); end
      ST_EXP:  begin mul_a = 36'(acc_r); mul_b = ROOT_TAB[k_r]; end
      ST_PEAK: begin mul_a = 36'(rd_r.peak); mul_b = acc_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    acc_status    = STAT_OK;
    if (accept) begin
      unique case (in_op)
        OP_CLEAR: begin
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
        end
        OP_ADD: begin
          if (in_core_radius == 16'd0) acc_status = STAT_ZERO_RAD;
          else if (!add_ok)            acc_status = STAT_FULL;
          if (add_ok) count_nxt = count_r + 1'b1;
          out_valid_nxt = 1'b1;
        end
        OP_PIXEL: out_valid_nxt = (count_r == '0);
        default:  out_valid_nxt = 1'b1;
      endcase
    end else if (state_r == ST_PEAK && !more_src) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      exp_r       <= 14'd6062;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) exp_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_ADD && add_ok) begin
      mem[count_r[IDX_W-1:0]] <= '{cx: in_pos_x, cy: in_pos_y, peak: in_peak,
                                   rad: in_core_radius};
    end
    rd_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          qx_r           <= in_pos_x;
          qy_r           <= in_pos_y;
          idx_r          <= '0;
          bright_r       <= '0;
          out_bright_r   <= '0;
          out_status_r   <= acc_status;
          out_count_r    <= count_nxt;
        end
      end
      ST_READ: ;
      ST_SQX: d2_r <= mul_p[29:0];
      ST_SQY: d2_r <= d2_r + mul_p[29:0];
      ST_RSQ: begin
        r2_r      <= mul_p[31:0];
        nz_r      <= 40'(mul_p[31:0]) + {2'd0, d2_r, 8'd0};
        p_r       <= 6'd39;
        log_sel_r <= 1'b0;
      end
      ST_NORM: begin
        if (nz_r[39] || nz_r == '0) begin
          z_r     <= nz_r[39:8];
          lbit_r  <= 5'(LOG_FRAC - 1);
          lfrac_r <= '0;
        end else if (nz_r[39:32] == 8'd0) begin
          nz_r <= nz_r << 8;
          p_r  <= p_r - 6'd8;
        end else begin
          nz_r <= nz_r << 1;
          p_r  <= p_r - 6'd1;
        end
      end
      ST_LOG: begin
        z_r     <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        lfrac_r <= frac_upd;
        lbit_r  <= lbit_r - 5'd1;
        if (lbit_r == 5'd0) begin
          if (!log_sel_r) begin
            la_r      <= lb;
            nz_r      <= 40'(r2_r);
            p_r       <= 6'd39;
            log_sel_r <= 1'b1;
          end else begin
            l_r <= (la_r > lb) ? la_r - lb : '0;
          end
        end
      end
      ST_MULE: begin
        n_r   <= mul_p[49:42];
        f_r   <= mul_p[41:18];
        k_r   <= 5'd1;
        acc_r <= 32'h8000_0000;
      end
      ST_EXP: begin
        if (f_r[23]) acc_r <= mul_p[62:31];
        f_r <= f_r << 1;
        k_r <= k_r + 5'd1;
      end
      ST_PEAK: begin
        bright_r     <= (sum > 65'(BRIGHT_TOP)) ? BRIGHT_TOP : sum[47:0];
        out_bright_r <= (sum > 65'(BRIGHT_TOP)) ? BRIGHT_TOP : sum[47:0];
        out_status_r <= STAT_OK;
        out_count_r  <= count_r;
        idx_r        <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_brightness   = out_bright_r;
  assign out_status       = out_status_r;
  assign out_source_count = out_count_r;

endmodule

@@ sv/bpsr_checker.sv @@
module bpsr_sva
  import bpsr_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  localparam int CNT_W = $clog2(MAX_SOURCES + 1)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_op,
  input logic             out_valid,
  input logic [47:0]      out_brightness,
  input logic [1:0]       out_status,
  input logic [CNT_W-1:0] out_source_count
);

  // A result only appears once the sequencer is back at rest.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // Table maintenance transactions answer in the next cycle.
  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != OP_PIXEL) |=> (out_valid && !busy))
    else $error("missing result for table transaction");

  // A pixel transaction either starts working or answers at once.
  a_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_PIXEL) |=> (busy || out_valid))
    else $error("pixel transaction dropped");

  // Rejections carry no brightness and never status 3, and the count never exceeds the table.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_brightness == '0 && out_status != 2'd3))
    else $error("bad status result");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_source_count <= CNT_W'(MAX_SOURCES)))
    else $error("source count out of range");

endmodule

bind beta_profile_sum_renderer bpsr_sva #(.MAX_SOURCES(MAX_SOURCES)) u_bpsr_sva (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_brightness(out_brightness), .out_status(out_status),
  .out_source_count(out_source_count)
);
